// ===== rtl/i2c_eeprom_byte_access_master_assert.svh =====
`ifndef I2C_EEPROM_BYTE_ACCESS_MASTER_ASSERT_SVH
`define I2C_EEPROM_BYTE_ACCESS_MASTER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define I2CM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/i2cm_pkg.sv =====
package i2cm_pkg;

	typedef struct packed {
		logic       go;
		logic       func;
		logic [7:0] word_address;
		logic [7:0] write_data;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
	} res_t;

	typedef struct packed {
		logic not_empty;
		req_t head;
	} queue_status_t;

	localparam logic CFG_DEVICE_ADDRESS = 1'b0;
	localparam logic CFG_ACK_WAIT_LIMIT = 1'b1;

	localparam logic [6:0] DEV_ADDR_RESET  = 7'd80;
	localparam logic [7:0] ACK_LIMIT_RESET = 8'd255;

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_S_SDA_HI = 4'd1;
	localparam logic [3:0] PH_S_SCL_HI = 4'd2;
	localparam logic [3:0] PH_S_SDA_LO = 4'd3;
	localparam logic [3:0] PH_WB_LO    = 4'd4;
	localparam logic [3:0] PH_WB_HI    = 4'd5;
	localparam logic [3:0] PH_WB_REL   = 4'd6;
	localparam logic [3:0] PH_ACK_HI   = 4'd7;
	localparam logic [3:0] PH_ACK_WAIT = 4'd8;
	localparam logic [3:0] PH_RB_REL   = 4'd9;
	localparam logic [3:0] PH_RB_HI    = 4'd10;
	localparam logic [3:0] PH_RB_LO    = 4'd11;
	localparam logic [3:0] PH_P_SDA_LO = 4'd12;
	localparam logic [3:0] PH_P_SCL_HI = 4'd13;
	localparam logic [3:0] PH_P_SDA_HI = 4'd14;

	localparam logic [2:0] STG_DEVICE  = 3'd0;
	localparam logic [2:0] STG_ADDRESS = 3'd1;
	localparam logic [2:0] STG_DATA    = 3'd2;
	localparam logic [2:0] STG_READ    = 3'd3;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

// ===== rtl/i2c_eeprom_byte_access_master.sv =====
// Byte write and random read master for a 24C02-style serial EEPROM. Every
// request is one half-bit tick and yields exactly one result with the line
// levels to drive, busy and done flags and the last byte read. Requests enter
// a two-entry queue, and the sequencer executes one tick per clock cycle
// when the output is not stalled, so the sustained rate is one request per
// cycle; each result is registered as its request leaves the queue head.
module i2c_eeprom_byte_access_master
	import i2cm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  req_t       in_req,
	output logic       out_valid,
	input  logic       out_stall,
	output res_t       out_res,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic          pop;
	logic          full;
	queue_status_t status;

	assign in_stall = full;

	i2cm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid && !full),
		.push_req (in_req),
		.full     (full),
		.pop      (pop),
		.status   (status)
	);

	i2cm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

endmodule

// ===== rtl/i2cm_queue.sv =====
module i2cm_queue
	import i2cm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  req_t          push_req,
	output logic          full,
	input  logic          pop,
	output queue_status_t status
);

	req_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full             = count_q[1];
	assign status.not_empty = (count_q != 2'd0);
	assign status.head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_req;
		end
	end

endmodule

// ===== rtl/i2cm_seq.sv =====
module i2cm_seq
	import i2cm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [7:0]    cfg_data,
	input  queue_status_t status,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output res_t          out_res
);

	logic [6:0] dev_addr_q;
	logic [7:0] ack_limit_q;

	logic [6:0] step_q;
	logic [3:0] bit_cnt_q;
	logic [7:0] shift_q;
	logic [7:0] ack_cnt_q;
	logic       func_q;
	logic [7:0] addr_q;
	logic [7:0] data_q;
	logic       scl_q;
	logic       sda_q;
	logic [7:0] rx_q;
	logic       out_valid_q;
	res_t       out_res_q;

	logic [6:0] n_step;
	logic [3:0] n_bit_cnt;
	logic [7:0] n_shift;
	logic [7:0] n_ack_cnt;
	logic       n_func;
	logic [7:0] n_addr;
	logic [7:0] n_data;
	logic       n_scl;
	logic       n_sda;
	logic [7:0] n_rx;
	logic       done;
	logic [3:0] phase;
	logic [2:0] stage;
	logic [7:0] dev_byte;
	logic [3:0] bit_inc;
	req_t       req;

	assign phase    = step_q[3:0];
	assign stage    = step_q[6:4];
	assign dev_byte = {dev_addr_q, 1'b0};
	assign bit_inc  = bit_cnt_q + 4'd1;
	assign req      = status.head;

	assign pop       = status.not_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_comb begin
		n_step    = '0;
		n_bit_cnt = bit_cnt_q;
		n_shift   = shift_q;
		n_ack_cnt = ack_cnt_q;
		n_func    = func_q;
		n_addr    = addr_q;
		n_data    = data_q;
		n_scl     = scl_q;
		n_sda     = sda_q;
		n_rx      = rx_q;
		done      = 1'b0;
		unique case (phase)
			PH_IDLE: begin
				if (req.go) begin
					n_func = req.func;
					n_addr = req.word_address;
					n_data = req.write_data;
					n_sda  = 1'b1;
					n_step = {STG_DEVICE, PH_S_SCL_HI};
				end
			end
			PH_S_SDA_HI: begin
				n_sda  = 1'b1;
				n_step = {stage, PH_S_SCL_HI};
			end
			PH_S_SCL_HI: begin
				n_scl  = 1'b1;
				n_step = {stage, PH_S_SDA_LO};
			end
			PH_S_SDA_LO: begin
				n_sda     = 1'b0;
				n_bit_cnt = 4'd0;
				n_step    = {stage, PH_WB_LO};
				if (stage == STG_DEVICE) begin
					n_shift = dev_byte;
				end else if (stage == STG_ADDRESS) begin
					n_shift = addr_q;
				end else begin
					n_shift = func_q ? (dev_byte | 8'd1) : data_q;
				end
			end
			PH_WB_LO: begin
				n_scl   = 1'b0;
				n_sda   = shift_q[7];
				n_shift = {shift_q[6:0], 1'b0};
				n_step  = {stage, PH_WB_HI};
			end
			PH_WB_HI: begin
				n_scl     = 1'b1;
				n_bit_cnt = bit_inc;
				n_step    = {stage, (bit_inc >= BITS_PER_BYTE) ? PH_WB_REL : PH_WB_LO};
			end
			PH_WB_REL: begin
				n_scl  = 1'b0;
				n_sda  = 1'b1;
				n_step = {stage, PH_ACK_HI};
			end
			PH_ACK_HI: begin
				n_scl     = 1'b1;
				n_ack_cnt = 8'd0;
				n_step    = {stage, PH_ACK_WAIT};
			end
			PH_ACK_WAIT: begin
				if (req.sda_in && (ack_cnt_q < ack_limit_q)) begin
					n_ack_cnt = ack_cnt_q + 8'd1;
					n_step    = step_q;
				end else begin
					n_scl = 1'b0;
					if (stage == STG_DEVICE) begin
						n_shift   = addr_q;
						n_bit_cnt = 4'd0;
						n_step    = {STG_ADDRESS, PH_WB_LO};
					end else if (stage == STG_ADDRESS) begin
						if (func_q) begin
							n_step = {STG_DATA, PH_S_SDA_HI};
						end else begin
							n_shift   = data_q;
							n_bit_cnt = 4'd0;
							n_step    = {STG_DATA, PH_WB_LO};
						end
					end else if ((stage == STG_DATA) && func_q) begin
						n_step = {STG_READ, PH_RB_REL};
					end else begin
						n_step = {stage, PH_P_SDA_LO};
					end
				end
			end
			PH_RB_REL: begin
				n_scl     = 1'b0;
				n_sda     = 1'b1;
				n_bit_cnt = 4'd0;
				n_shift   = 8'd0;
				n_step    = {stage, PH_RB_HI};
			end
			PH_RB_HI: begin
				n_scl  = 1'b1;
				n_step = {stage, PH_RB_LO};
			end
			PH_RB_LO: begin
				n_shift   = {shift_q[6:0], req.sda_in};
				n_scl     = 1'b0;
				n_bit_cnt = bit_inc;
				if (bit_inc >= BITS_PER_BYTE) begin
					n_rx   = {shift_q[6:0], req.sda_in};
					n_step = {stage, PH_P_SDA_LO};
				end else begin
					n_step = {stage, PH_RB_HI};
				end
			end
			PH_P_SDA_LO: begin
				n_sda  = 1'b0;
				n_step = {stage, PH_P_SCL_HI};
			end
			PH_P_SCL_HI: begin
				n_scl  = 1'b1;
				n_step = {stage, PH_P_SDA_HI};
			end
			PH_P_SDA_HI: begin
				n_sda  = 1'b1;
				done   = 1'b1;
				n_step = '0;
			end
			default: begin
				n_step = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q  <= DEV_ADDR_RESET;
			ack_limit_q <= ACK_LIMIT_RESET;
			step_q      <= '0;
			bit_cnt_q   <= '0;
			shift_q     <= '0;
			ack_cnt_q   <= '0;
			func_q      <= 1'b0;
			addr_q      <= '0;
			data_q      <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			rx_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DEVICE_ADDRESS: dev_addr_q  <= cfg_data[6:0];
					CFG_ACK_WAIT_LIMIT: ack_limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (pop) begin
				step_q    <= n_step;
				bit_cnt_q <= n_bit_cnt;
				shift_q   <= n_shift;
				ack_cnt_q <= n_ack_cnt;
				func_q    <= n_func;
				addr_q    <= n_addr;
				data_q    <= n_data;
				scl_q     <= n_scl;
				sda_q     <= n_sda;
				rx_q      <= n_rx;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_res_q.scl_level <= n_scl;
			out_res_q.sda_level <= n_sda;
			out_res_q.busy_res  <= (n_step != 7'd0) || done;
			out_res_q.done_res  <= done;
			out_res_q.read_data <= n_rx;
		end
	end

endmodule

// ===== rtl/i2cm_checker.sv =====
`include "i2c_eeprom_byte_access_master_assert.svh"

module i2cm_checker
	import i2cm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input req_t       in_req,
	input logic       out_valid,
	input logic       out_stall,
	input res_t       out_res
);

	logic done_shown;
	logic stalled;
	logic in_waiting;

	assign done_shown = out_valid && out_res.done_res;
	assign stalled    = out_valid && out_stall;
	assign in_waiting = in_valid && in_stall;

	`I2CM_ASSERT_NOW(a_done_busy, clk, arst_n, done_shown, out_res.busy_res, "done without busy")
	`I2CM_ASSERT_NOW(a_done_lines, clk, arst_n, done_shown,
		out_res.scl_level && out_res.sda_level, "stop ends with a line low")
	`I2CM_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled,
		out_valid && $stable(out_res), "stalled request changed")
	`I2CM_ASSERT_NEXT(a_in_hold, clk, arst_n, in_waiting,
		in_valid && $stable(in_req), "stalled input request changed")

endmodule

bind i2c_eeprom_byte_access_master i2cm_checker u_i2cm_checker (.*);
